// File: rtl/core/hbsf_pkg.sv
`default_nettype none
package hbsf_pkg;

	// Widths of the frame size register and the frame bit counter.
	localparam int unsigned SIZE_W         = 11;
	localparam int unsigned MAX_FRAME_BITS = 1024;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_FRAME_BITS);

	// Flag octet and the run length that forces a stuffed zero.
	localparam logic [7:0] FLAG_PATTERN = 8'b0111_1110;
	localparam int unsigned RUN_W       = 3;
	localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(5);

	// Command queue between the classifier and the serializer.
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	// Serializer phases: opening flag, data bit, stuffed zero, closing flag.
	localparam int unsigned PH_W = 5;
	localparam logic [PH_W-1:0] PH_OPEN_FIRST  = PH_W'(0);
	localparam logic [PH_W-1:0] PH_OPEN_LAST   = PH_W'(7);
	localparam logic [PH_W-1:0] PH_DATA        = PH_W'(8);
	localparam logic [PH_W-1:0] PH_STUFF       = PH_W'(9);
	localparam logic [PH_W-1:0] PH_CLOSE_FIRST = PH_W'(10);
	localparam logic [PH_W-1:0] PH_CLOSE_LAST  = PH_W'(17);

	// One classified payload bit: what the serializer must send for it.
	typedef struct packed {
		logic data;
		logic open;
		logic stuff;
		logic close;
	} cmd_t;

	// One line bit on its way to the result port.
	typedef struct packed {
		logic line_bit;
		logic is_flag;
		logic last_of_run;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/core/hdlc_bit_stuff_framer_top.sv
// HDLC bit-stuffing framer, transmit side.
// Input channel: drive data_bit with push; the bit is taken at a clock edge
// where push is high and full is low. Result channel: while empty is low the
// oldest line bit sits on line_bit, is_flag and last_of_run; pop at an edge
// where empty is low takes it. last_of_run marks the final line bit caused by
// one payload bit (flag bits, the data bit, a stuffed zero).
// Configuration: frame_size is written at an edge where cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// The first line bit of a payload bit passes through the command queue and
// then the output register. Throughput: one line bit per cycle while the
// receiver pops, set by the serializer, which emits one bit per cycle from a
// four-entry command queue; input flows at one bit per cycle inside a frame
// without stuffing and stalls (full high) while flags or stuffed zeros drain.
// Reset: clears the queue and output register and restarts at a frame start
// with frame_size 8. If the receiver stops popping, the output holds its bit
// and the queue fills, after which full stays high until pops resume.
`default_nettype none
module hdlc_bit_stuff_framer_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         data_bit,
	output logic                              empty,
	input  wire logic                         pop,
	output logic                              line_bit,
	output logic                              is_flag,
	output logic                              last_of_run,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [hbsf_pkg::SIZE_W-1:0]  frame_size
);

	hbsf_pkg::cmd_t    front_cmd;
	hbsf_pkg::cmd_t    head_cmd;
	hbsf_pkg::result_t res;
	logic              accept;
	logic              q_empty;
	logic              q_pop;
	logic              res_valid;

	assign cfg_ready   = 1'b1;
	assign accept      = push && !full;
	assign empty       = !res_valid;
	assign line_bit    = res.line_bit;
	assign is_flag     = res.is_flag;
	assign last_of_run = res.last_of_run;

	// Classifier: frame position, run tracking, command per payload bit.
	hbsf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_size (frame_size),
		.accept   (accept),
		.data_bit (data_bit),
		.cmd      (front_cmd)
	);

	// Command queue decoupling classifier and serializer.
	hbsf_cmd_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (accept),
		.wr_cmd(front_cmd),
		.full  (full),
		.rd_en (q_pop),
		.rd_cmd(head_cmd),
		.empty (q_empty)
	);

	// Serializer with its output register.
	hbsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (head_cmd),
		.cmd_empty(q_empty),
		.cmd_pop  (q_pop),
		.res      (res),
		.res_valid(res_valid),
		.res_pop  (pop)
	);

endmodule
`default_nettype wire

// File: rtl/core/hbsf_front.sv
`default_nettype none
module hbsf_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [hbsf_pkg::SIZE_W-1:0]   cfg_size,
	input  wire logic                          accept,
	input  wire logic                          data_bit,
	output hbsf_pkg::cmd_t                     cmd
);

	logic [hbsf_pkg::SIZE_W-1:0] frame_size_q;
	logic [hbsf_pkg::SIZE_W-1:0] bit_in_frame_q;
	logic [hbsf_pkg::RUN_W-1:0]  ones_run_q;

	logic [hbsf_pkg::SIZE_W-1:0] eff_size;
	logic [hbsf_pkg::SIZE_W-1:0] bif_next;
	logic [hbsf_pkg::RUN_W-1:0]  run_base;
	logic [hbsf_pkg::RUN_W-1:0]  run_inc;
	logic [hbsf_pkg::RUN_W-1:0]  run_next;

	// Clamp the configured size into the legal frame range.
	always_comb begin
		eff_size = frame_size_q;
		if (frame_size_q == '0) begin
			eff_size = hbsf_pkg::SIZE_W'(1);
		end else if (frame_size_q > hbsf_pkg::SIZE_MAX) begin
			eff_size = hbsf_pkg::SIZE_MAX;
		end
	end

	// Classify the incoming bit: flag before it, stuffed zero, flag after it.
	always_comb begin
		cmd.data  = data_bit;
		cmd.open  = (bit_in_frame_q == '0);
		run_base  = cmd.open ? '0 : ones_run_q;
		run_inc   = run_base + hbsf_pkg::RUN_W'(1);
		cmd.stuff = data_bit && (run_inc >= hbsf_pkg::RUN_LIMIT);
		if (!data_bit || cmd.stuff) begin
			run_next = '0;
		end else begin
			run_next = run_inc;
		end
		bif_next  = bit_in_frame_q + hbsf_pkg::SIZE_W'(1);
		cmd.close = (bif_next >= eff_size);
	end

	// Frame size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q <= hbsf_pkg::SIZE_RESET;
		end else if (cfg_valid) begin
			frame_size_q <= cfg_size;
		end
	end

	// Frame position and run of ones, advanced once per accepted bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_in_frame_q <= '0;
			ones_run_q     <= '0;
		end else if (accept) begin
			bit_in_frame_q <= cmd.close ? '0 : bif_next;
			ones_run_q     <= cmd.close ? '0 : run_next;
		end
	end

`ifndef NO_ASSERTIONS
	// A closing bit always returns the frame to its start.
	a_close_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.close |=> bit_in_frame_q == '0)
		else $error("frame counter did not restart after a closing bit");

	// Stuffing keeps the stored run of ones below the limit.
	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ones_run_q < hbsf_pkg::RUN_LIMIT)
		else $error("run of ones reached the stuffing limit");
`endif

endmodule
`default_nettype wire

// File: rtl/core/hbsf_cmd_fifo.sv
`default_nettype none
module hbsf_cmd_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire hbsf_pkg::cmd_t   wr_cmd,
	output logic                  full,
	input  wire logic             rd_en,
	output hbsf_pkg::cmd_t        rd_cmd,
	output logic                  empty
);

	hbsf_pkg::cmd_t                 mem [hbsf_pkg::FIFO_DEPTH];
	logic [hbsf_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [hbsf_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [hbsf_pkg::FIFO_AW:0]     count_q;

	assign full   = (count_q == (hbsf_pkg::FIFO_AW+1)'(hbsf_pkg::FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem[rd_ptr_q];

	// Command storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + hbsf_pkg::FIFO_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + hbsf_pkg::FIFO_AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (hbsf_pkg::FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (hbsf_pkg::FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The fill count always matches the pointer distance.
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[hbsf_pkg::FIFO_AW-1:0] == (wr_ptr_q - rd_ptr_q))
		else $error("command queue count disagrees with its pointers");
`endif

endmodule
`default_nettype wire

// File: rtl/core/hbsf_back.sv
`default_nettype none
module hbsf_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hbsf_pkg::cmd_t  cmd,
	input  wire logic            cmd_empty,
	output logic                 cmd_pop,
	output hbsf_pkg::result_t    res,
	output logic                 res_valid,
	input  wire logic            res_pop
);

	logic                       mid_q;
	logic [hbsf_pkg::PH_W-1:0]  phase_q;
	logic                       out_valid_q;
	hbsf_pkg::result_t          out_q;

	logic                       advance;
	logic [hbsf_pkg::PH_W-1:0]  phase;
	logic [hbsf_pkg::PH_W-1:0]  phase_next;
	logic [hbsf_pkg::PH_W-1:0]  close_off;
	logic [2:0]                 flag_idx;
	logic                       done;
	hbsf_pkg::result_t          cur;

	assign advance   = !cmd_empty && (!out_valid_q || res_pop);
	assign cmd_pop   = advance && done;
	assign res       = out_q;
	assign res_valid = out_valid_q;
	assign close_off = phase - hbsf_pkg::PH_CLOSE_FIRST;

	// Current phase: a fresh command starts at its opening flag or its data bit.
	always_comb begin
		if (mid_q) begin
			phase = phase_q;
		end else if (cmd.open) begin
			phase = hbsf_pkg::PH_OPEN_FIRST;
		end else begin
			phase = hbsf_pkg::PH_DATA;
		end
	end

	// Next phase, and whether this is the last line bit of the command.
	always_comb begin
		phase_next = phase;
		done       = 1'b0;
		case (phase) inside
			[hbsf_pkg::PH_OPEN_FIRST:hbsf_pkg::PH_OPEN_LAST-1]: begin
				phase_next = phase + hbsf_pkg::PH_W'(1);
			end
			hbsf_pkg::PH_OPEN_LAST: begin
				phase_next = hbsf_pkg::PH_DATA;
			end
			hbsf_pkg::PH_DATA: begin
				if (cmd.stuff) begin
					phase_next = hbsf_pkg::PH_STUFF;
				end else if (cmd.close) begin
					phase_next = hbsf_pkg::PH_CLOSE_FIRST;
				end else begin
					done = 1'b1;
				end
			end
			hbsf_pkg::PH_STUFF: begin
				if (cmd.close) begin
					phase_next = hbsf_pkg::PH_CLOSE_FIRST;
				end else begin
					done = 1'b1;
				end
			end
			[hbsf_pkg::PH_CLOSE_FIRST:hbsf_pkg::PH_CLOSE_LAST-1]: begin
				phase_next = phase + hbsf_pkg::PH_W'(1);
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// Line bit for the current phase.
	always_comb begin
		flag_idx        = phase[2:0];
		cur.line_bit    = 1'b0;
		cur.is_flag     = 1'b0;
		cur.last_of_run = done;
		case (phase) inside
			[hbsf_pkg::PH_OPEN_FIRST:hbsf_pkg::PH_OPEN_LAST]: begin
				cur.is_flag  = 1'b1;
				cur.line_bit = hbsf_pkg::FLAG_PATTERN[3'd7 - flag_idx];
			end
			hbsf_pkg::PH_DATA: begin
				cur.line_bit = cmd.data;
			end
			[hbsf_pkg::PH_CLOSE_FIRST:hbsf_pkg::PH_CLOSE_LAST]: begin
				flag_idx     = close_off[2:0];
				cur.is_flag  = 1'b1;
				cur.line_bit = hbsf_pkg::FLAG_PATTERN[3'd7 - flag_idx];
			end
			default: begin
				cur.line_bit = 1'b0;
			end
		endcase
	end

	// Sequencer position within the command at the queue head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q   <= 1'b0;
			phase_q <= '0;
		end else if (advance) begin
			mid_q   <= !done;
			phase_q <= phase_next;
		end
	end

	// Output register: holds a result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= cur;
		end
	end

`ifndef NO_ASSERTIONS
	// A command in progress stays at the queue head until it finishes.
	a_mid_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		mid_q |-> !cmd_empty)
		else $error("serializer lost its command mid-sequence");

	// A stored phase always lies inside the sequence.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		mid_q |-> phase_q <= hbsf_pkg::PH_CLOSE_LAST)
		else $error("serializer phase out of range");
`endif

endmodule
`default_nettype wire
